### hdl/ips_pkg.sv
package ips_pkg;

   // Stage codes, as reported on stage_now.
   typedef enum logic [2:0] {
      STAGE_OFF       = 3'd0,
      STAGE_ACC_ON    = 3'd1,
      STAGE_TO_ON     = 3'd2,
      STAGE_TO_ACC_ON = 3'd3,
      STAGE_ON        = 3'd4,
      STAGE_SHUTDOWN  = 3'd5
   } stage_type;

   // Register indexes on the configuration port (byte address / 4).
   localparam logic [1:0] CSR_ACC_CONFIRM = 2'd0;
   localparam logic [1:0] CSR_KEY_HOLD    = 2'd1;
   localparam logic [1:0] CSR_ACC_LOSS    = 2'd2;

   localparam logic [7:0] ACC_CONFIRM_RESET = 8'd10;
   localparam logic [7:0] KEY_HOLD_RESET    = 8'd10;
   localparam logic [7:0] ACC_LOSS_RESET    = 8'd49;

   // Bit positions in the status word.
   localparam int unsigned FLAG_ADC_BIT  = 15;
   localparam int unsigned FLAG_KEY_BIT  = 14;
   localparam int unsigned FLAG_NEXT_BIT = 0;
   localparam int unsigned FLAG_PREV_BIT = 1;
   localparam int unsigned FLAG_UP_BIT   = 2;
   localparam int unsigned FLAG_DOWN_BIT = 3;

   typedef struct packed {
      logic acc_on;
      logic key_held;
      logic power_good;
      logic volume_up;
      logic volume_down;
      logic tune_next;
      logic tune_prev;
      logic adc_updated;
   } req_type;

   typedef struct packed {
      logic        lamp_green;
      logic        led_red;
      logic        lamp_yellow;
      logic        power_toggle;
      logic        host_irq;
      logic [15:0] report_word;
      logic [2:0]  stage_now;
   } rsp_type;

endpackage

### hdl/ignition_power_sequencer.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  ips_pkg::req_type, one 100 ms tick
// rsp       out        rsp_valid / rsp_ready  ips_pkg::rsp_type, one per tick
// csr       in         APB, pready always 1   three 8-bit registers at 0x0, 0x4, 0x8
//
// The stage machine and the indicator logic sit between the state registers and the
// result register, so a word is taken every cycle while the rsp side is not stalled.
// req_ready is high whenever the result register is empty or is being emptied.
// A stalled rsp side holds the result and stops intake until it is taken.
// Synchronous reset returns the machine to off and the registers to their defaults.
module ignition_power_sequencer #(
   parameter int unsigned COUNT_WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ips_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ips_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int unsigned CMP_WIDTH = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

   logic [7:0] acc_confirm_ff;
   logic [7:0] key_hold_ff;
   logic [7:0] acc_loss_ff;

   ips_pkg::stage_type     stage_ff, stage_in;
   logic                   needs_key_ff, needs_key_in;
   logic                   waiting_ff, waiting_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic             rsp_valid_ff, rsp_valid_in;
   ips_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   csr_write;
   logic [1:0]             csr_index;
   logic [COUNT_WIDTH-1:0] confirm_load;
   logic [COUNT_WIDTH-1:0] hold_load;
   logic [COUNT_WIDTH-1:0] count_inc;
   logic                   count_le_one;
   logic                   any_key;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign accept     = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   // Loaded wait lengths saturate at the counter's maximum.
   function automatic logic [COUNT_WIDTH-1:0] sat_load(input logic [7:0] value);
      logic [CMP_WIDTH-1:0] ext;
      ext = CMP_WIDTH'(value);
      if (ext > CMP_WIDTH'(CNT_MAX)) begin
         return CNT_MAX;
      end
      return ext[COUNT_WIDTH-1:0];
   endfunction

   assign confirm_load = sat_load(acc_confirm_ff);
   assign hold_load    = sat_load(key_hold_ff);
   assign count_inc    = (count_ff < CNT_MAX) ? count_ff + 1'b1 : count_ff;
   assign count_le_one = count_ff <= COUNT_WIDTH'(1);
   assign any_key      = req_data.volume_up || req_data.volume_down
                         || req_data.tune_next || req_data.tune_prev;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_confirm_ff <= ips_pkg::ACC_CONFIRM_RESET;
         key_hold_ff    <= ips_pkg::KEY_HOLD_RESET;
         acc_loss_ff    <= ips_pkg::ACC_LOSS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            ips_pkg::CSR_ACC_CONFIRM: acc_confirm_ff <= csr_pwdata[7:0];
            ips_pkg::CSR_KEY_HOLD:    key_hold_ff    <= csr_pwdata[7:0];
            ips_pkg::CSR_ACC_LOSS:    acc_loss_ff    <= csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         ips_pkg::CSR_ACC_CONFIRM: csr_prdata = {24'd0, acc_confirm_ff};
         ips_pkg::CSR_KEY_HOLD:    csr_prdata = {24'd0, key_hold_ff};
         ips_pkg::CSR_ACC_LOSS:    csr_prdata = {24'd0, acc_loss_ff};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   // Next state of the stage machine.
   always_comb begin
      stage_in     = stage_ff;
      needs_key_in = needs_key_ff;
      waiting_in   = waiting_ff;
      count_in     = count_ff;
      unique case (stage_ff)
         ips_pkg::STAGE_OFF: begin
            needs_key_in = 1'b0;
            if (waiting_ff) begin
               if (count_le_one) begin
                  waiting_in = 1'b0;
                  count_in   = '0;
                  if (req_data.acc_on) begin
                     stage_in = ips_pkg::STAGE_ACC_ON;
                  end else if (req_data.power_good) begin
                     stage_in = ips_pkg::STAGE_SHUTDOWN;
                  end
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end else if (req_data.acc_on) begin
               waiting_in = 1'b1;
               count_in   = confirm_load;
            end else if (req_data.power_good) begin
               stage_in = ips_pkg::STAGE_SHUTDOWN;
            end
         end
         ips_pkg::STAGE_ACC_ON: begin
            // Ignition is not watched while the key hold is being timed.
            if (waiting_ff) begin
               if (count_le_one) begin
                  waiting_in = 1'b0;
                  count_in   = '0;
                  if (req_data.key_held) begin
                     stage_in = ips_pkg::STAGE_TO_ON;
                  end
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end else if (!req_data.acc_on) begin
               stage_in = ips_pkg::STAGE_OFF;
            end else if (!needs_key_ff) begin
               stage_in = ips_pkg::STAGE_TO_ACC_ON;
            end else if (req_data.key_held) begin
               waiting_in = 1'b1;
               count_in   = hold_load;
            end
         end
         ips_pkg::STAGE_TO_ON, ips_pkg::STAGE_TO_ACC_ON: begin
            if (req_data.power_good) begin
               stage_in     = ips_pkg::STAGE_ON;
               needs_key_in = 1'b0;
            end
         end
         ips_pkg::STAGE_ON: begin
            if (waiting_ff) begin
               if (req_data.acc_on) begin
                  waiting_in = 1'b0;
                  count_in   = '0;
               end else begin
                  count_in = count_inc;
                  if (CMP_WIDTH'(count_inc) >= CMP_WIDTH'(acc_loss_ff)) begin
                     stage_in = ips_pkg::STAGE_SHUTDOWN;
                  end
               end
            end else if (!req_data.power_good) begin
               stage_in     = ips_pkg::STAGE_ACC_ON;
               needs_key_in = 1'b1;
            end else if (!req_data.acc_on) begin
               waiting_in = 1'b1;
               count_in   = COUNT_WIDTH'(1);
               if (acc_loss_ff <= 8'd1) begin
                  stage_in = ips_pkg::STAGE_SHUTDOWN;
               end
            end
         end
         ips_pkg::STAGE_SHUTDOWN: begin
            if (!req_data.power_good) begin
               stage_in = ips_pkg::STAGE_OFF;
            end
         end
         default: begin
            stage_in     = ips_pkg::STAGE_OFF;
            needs_key_in = 1'b0;
         end
      endcase
      if (stage_in != stage_ff) begin
         waiting_in = 1'b0;
         count_in   = '0;
      end
   end

   // Indicators and the status report for this tick.
   always_comb begin
      rsp_data_in = '0;
      unique case (stage_ff)
         ips_pkg::STAGE_OFF: begin
            rsp_data_in.lamp_yellow = (waiting_ff && !count_le_one) || req_data.acc_on;
         end
         ips_pkg::STAGE_ACC_ON: begin
            rsp_data_in.lamp_yellow = 1'b1;
            rsp_data_in.led_red     = needs_key_ff;
         end
         ips_pkg::STAGE_TO_ON, ips_pkg::STAGE_TO_ACC_ON: begin
            rsp_data_in.power_toggle = !req_data.power_good;
            rsp_data_in.led_red      = !req_data.power_good;
            rsp_data_in.lamp_yellow  = !req_data.power_good;
         end
         ips_pkg::STAGE_ON: begin
            rsp_data_in.lamp_green  = 1'b1;
            rsp_data_in.lamp_yellow = !req_data.acc_on && (waiting_ff || req_data.power_good);
            // Flags are reported in the tick they arrive, so nothing is carried over.
            if (any_key || req_data.adc_updated) begin
               rsp_data_in.host_irq = 1'b1;
               rsp_data_in.report_word[ips_pkg::FLAG_ADC_BIT]  = req_data.adc_updated;
               rsp_data_in.report_word[ips_pkg::FLAG_KEY_BIT]  = any_key;
               rsp_data_in.report_word[ips_pkg::FLAG_NEXT_BIT] = req_data.tune_next;
               rsp_data_in.report_word[ips_pkg::FLAG_PREV_BIT] = req_data.tune_prev;
               rsp_data_in.report_word[ips_pkg::FLAG_UP_BIT]   = req_data.volume_up;
               rsp_data_in.report_word[ips_pkg::FLAG_DOWN_BIT] = req_data.volume_down;
            end
         end
         ips_pkg::STAGE_SHUTDOWN: begin
            rsp_data_in.led_red      = req_data.power_good;
            rsp_data_in.power_toggle = req_data.power_good;
         end
         default: begin
         end
      endcase
      rsp_data_in.stage_now = stage_in;
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff     <= ips_pkg::STAGE_OFF;
         needs_key_ff <= 1'b0;
         waiting_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            stage_ff     <= stage_in;
            needs_key_ff <= needs_key_in;
            waiting_ff   <= waiting_in;
            count_ff     <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
